[hdl/mf3_pkg.sv]
// shared types, constants and compare helpers for the 3x3 median filter
`default_nettype none

package mf3_pkg;

  localparam int PIX_W          = 8;
  localparam int ROW_W          = 16;
  localparam int COL_W          = 11;
  localparam int IMG_W_W        = 12;
  localparam int IMG_H_W        = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int IMG_WIDTH_RST  = 640;
  localparam int IMG_HEIGHT_RST = 480;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  // one window column, sorted
  typedef struct packed {
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] md;
    logic [PIX_W-1:0] hi;
  } col_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } res_t;

  // results handed to the output queue, e0 first
  typedef struct packed {
    logic [1:0] cnt;
    res_t       e0;
    res_t       e1;
  } push_t;

  function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] t;
    t = (a < b) ? a : b;
    return (t < c) ? t : c;
  endfunction

  function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] t;
    t = (a > b) ? a : b;
    return (t > c) ? t : c;
  endfunction

  function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] lo_ab;
    logic [PIX_W-1:0] hi_ab;
    logic [PIX_W-1:0] t;
    lo_ab = (a < b) ? a : b;
    hi_ab = (a < b) ? b : a;
    t     = (hi_ab < c) ? hi_ab : c;
    return (lo_ab > t) ? lo_ab : t;
  endfunction

  function automatic col_t sort3(input logic [PIX_W-1:0] a,
                                 input logic [PIX_W-1:0] b,
                                 input logic [PIX_W-1:0] c);
    col_t s;
    s.lo = min3(a, b, c);
    s.md = med3(a, b, c);
    s.hi = max3(a, b, c);
    return s;
  endfunction

endpackage

`default_nettype wire

[hdl/mf3_line_buf.sv]
// two line stores holding the previous two rows, registered read
`default_nettype none

module mf3_line_buf #(
  parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic [AW-1:0]            rd_addr_i,
  output logic      [mf3_pkg::PIX_W-1:0] rd_upper_o,
  output logic      [mf3_pkg::PIX_W-1:0] rd_lower_o,
  input  wire logic                     wr_en_i,
  input  wire logic [AW-1:0]            wr_addr_i,
  input  wire logic [mf3_pkg::PIX_W-1:0] wr_upper_i,
  input  wire logic [mf3_pkg::PIX_W-1:0] wr_lower_i
);

  logic [mf3_pkg::PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [mf3_pkg::PIX_W-1:0] lower_mem [MAX_WIDTH];
  logic [mf3_pkg::PIX_W-1:0] upper_q;
  logic [mf3_pkg::PIX_W-1:0] lower_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[wr_addr_i] <= wr_upper_i;
      lower_mem[wr_addr_i] <= wr_lower_i;
    end
    if (rd_en_i) begin
      upper_q <= upper_mem[rd_addr_i];
      lower_q <= lower_mem[rd_addr_i];
    end
  end

  assign rd_upper_o = upper_q;
  assign rd_lower_o = lower_q;

endmodule

`default_nettype wire

[hdl/mf3_window.sv]
// 3x3 window kept as sorted columns, median of nine from column sorts
`default_nettype none

module mf3_window (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      shift_i,
  input  wire logic [mf3_pkg::PIX_W-1:0] top_i,
  input  wire logic [mf3_pkg::PIX_W-1:0] mid_i,
  input  wire logic [mf3_pkg::PIX_W-1:0] bot_i,
  output logic      [mf3_pkg::PIX_W-1:0] median_o
);

  mf3_pkg::col_t old_q;
  mf3_pkg::col_t prev_q;
  mf3_pkg::col_t new_col;
  logic [mf3_pkg::PIX_W-1:0] max_lo;
  logic [mf3_pkg::PIX_W-1:0] med_md;
  logic [mf3_pkg::PIX_W-1:0] min_hi;

  always_comb begin
    new_col  = mf3_pkg::sort3(top_i, mid_i, bot_i);
    max_lo   = mf3_pkg::max3(old_q.lo, prev_q.lo, new_col.lo);
    med_md   = mf3_pkg::med3(old_q.md, prev_q.md, new_col.md);
    min_hi   = mf3_pkg::min3(old_q.hi, prev_q.hi, new_col.hi);
    median_o = mf3_pkg::med3(max_lo, med_md, min_hi);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_q  <= '0;
      prev_q <= '0;
    end else if (shift_i) begin
      old_q  <= prev_q;
      prev_q <= new_col;
    end
  end

endmodule

`default_nettype wire

[hdl/mf3_out_fifo.sv]
// small queue taking up to two results per cycle, one out per cycle unless stalled
`default_nettype none

module mf3_out_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mf3_pkg::push_t push_i,
  output logic                room_o,
  output logic                valid_o,
  input  wire logic           stall_i,
  output mf3_pkg::res_t       head_o
);

  mf3_pkg::res_t                     entry_q [mf3_pkg::FIFO_DEPTH];
  logic [mf3_pkg::FIFO_PTR_W-1:0]    wr_ptr_q;
  logic [mf3_pkg::FIFO_PTR_W-1:0]    rd_ptr_q;
  logic [mf3_pkg::FIFO_CNT_W-1:0]    cnt_q;
  logic                              pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && !stall_i;
  assign room_o  = (cnt_q <= mf3_pkg::FIFO_CNT_W'(mf3_pkg::FIFO_DEPTH - 2));
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      entry_q[wr_ptr_q] <= push_i.e0;
    end
    if (push_i.cnt == 2'd2) begin
      entry_q[wr_ptr_q + mf3_pkg::FIFO_PTR_W'(1)] <= push_i.e1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + mf3_pkg::FIFO_PTR_W'(push_i.cnt);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + mf3_pkg::FIFO_PTR_W'(1);
      end
      cnt_q <= cnt_q + mf3_pkg::FIFO_CNT_W'(push_i.cnt) - mf3_pkg::FIFO_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

[hdl/median_filter_3x3.sv]
// streaming 3x3 median filter for 8-bit grey frames, top level
//
// pixels enter in raster order on the input channel (in_valid_i, in_stall_o,
// pixel_in_i), one transaction per pixel. results leave on the output channel
// (out_valid_o, out_stall_i) with pixel, row, column and last flag.
// border pixels are copied when they arrive; an interior pixel's median comes
// out when its lower-right neighbour arrives, ahead of that neighbour's copy.
// accepted pixels pass the input register stage, then the result queue.
// throughput is one pixel per cycle while in_stall_o is low; a pixel in the
// last column or last row from row 2 / column 2 on yields two results, which
// leave one at a time via the single output port behind a four-entry queue.
// frame size is set through the write port (cfg_we_i, cfg_idx_i, cfg_data_i);
// a write restarts the frame at row 0, column 0; the user writes only while
// idle (not enforced). reset clears the pipeline, queue and counters and loads
// a 640x480 frame. when the receiver stalls, results wait in the queue and
// in_stall_o rises once the queue cannot take another pixel's results.
`default_nettype none

module median_filter_3x3 #(
  parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mf3_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mf3_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [mf3_pkg::PIX_W-1:0]      pixel_in_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [mf3_pkg::PIX_W-1:0]      pixel_out_o,
  output logic      [mf3_pkg::ROW_W-1:0]      out_row_o,
  output logic      [mf3_pkg::COL_W-1:0]      out_col_o,
  output logic                                last_o
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RstW = (mf3_pkg::IMG_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH
                                                             : mf3_pkg::IMG_WIDTH_RST;

  logic [CW-1:0]                  wm1_q;
  logic [mf3_pkg::ROW_W-1:0]      hm1_q;
  logic [CW-1:0]                  col_q;
  logic [mf3_pkg::ROW_W-1:0]      row_q;
  logic [mf3_pkg::IMG_W_W-1:0]    w_raw;
  logic [mf3_pkg::IMG_H_W-1:0]    h_raw;
  logic [CW-1:0]                  wm1_d;
  logic [mf3_pkg::ROW_W-1:0]      hm1_d;
  logic                           cfg_hit;

  logic                           s1_valid_q;
  logic [mf3_pkg::PIX_W-1:0]      s1_pix_q;
  logic [mf3_pkg::ROW_W-1:0]      s1_row_q;
  logic [CW-1:0]                  s1_col_q;
  logic                           s1_med_q;
  logic                           s1_bord_q;
  logic                           s1_adv;
  logic                           accept;
  logic                           room;

  logic [mf3_pkg::PIX_W-1:0]      rd_upper;
  logic [mf3_pkg::PIX_W-1:0]      rd_lower;
  logic [mf3_pkg::PIX_W-1:0]      median;
  mf3_pkg::res_t                  res_med;
  mf3_pkg::res_t                  res_bord;
  mf3_pkg::push_t                 push;
  mf3_pkg::res_t                  head;

  // configuration decode
  assign w_raw   = cfg_data_i[mf3_pkg::IMG_W_W-1:0];
  assign h_raw   = cfg_data_i[mf3_pkg::IMG_H_W-1:0];
  assign cfg_hit = cfg_we_i && ((cfg_idx_i == mf3_pkg::REG_IMAGE_WIDTH) ||
                                (cfg_idx_i == mf3_pkg::REG_IMAGE_HEIGHT));

  always_comb begin
    if (w_raw == '0) begin
      wm1_d = '0;
    end else if (32'(w_raw) > 32'(MAX_WIDTH)) begin
      wm1_d = CW'(MAX_WIDTH - 1);
    end else begin
      wm1_d = CW'(w_raw - mf3_pkg::IMG_W_W'(1));
    end
    hm1_d = (h_raw == '0) ? '0 : h_raw - mf3_pkg::ROW_W'(1);
  end

  // handshake
  assign s1_adv     = s1_valid_q && room;
  assign in_stall_o = s1_valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;

  // frame size and position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q <= CW'(RstW - 1);
      hm1_q <= mf3_pkg::ROW_W'(mf3_pkg::IMG_HEIGHT_RST - 1);
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_hit) begin
      if (cfg_idx_i == mf3_pkg::REG_IMAGE_WIDTH) begin
        wm1_q <= wm1_d;
      end else begin
        hm1_q <= hm1_d;
      end
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_q == wm1_q) begin
        col_q <= '0;
        row_q <= (row_q == hm1_q) ? '0 : row_q + mf3_pkg::ROW_W'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // input register stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pixel_in_i;
      s1_row_q  <= row_q;
      s1_col_q  <= col_q;
      s1_med_q  <= (row_q >= mf3_pkg::ROW_W'(2)) && (col_q >= CW'(2));
      s1_bord_q <= (row_q == '0) || (row_q == hm1_q) || (col_q == '0) ||
                   (col_q == wm1_q);
    end
  end

  mf3_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i      (clk_i),
    .rd_en_i    (accept),
    .rd_addr_i  (col_q),
    .rd_upper_o (rd_upper),
    .rd_lower_o (rd_lower),
    .wr_en_i    (s1_adv),
    .wr_addr_i  (s1_col_q),
    .wr_upper_i (rd_lower),
    .wr_lower_i (s1_pix_q)
  );

  mf3_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (s1_adv),
    .top_i    (rd_upper),
    .mid_i    (rd_lower),
    .bot_i    (s1_pix_q),
    .median_o (median)
  );

  // result assembly, median before the border copy
  always_comb begin
    res_med.pix  = median;
    res_med.row  = s1_row_q - mf3_pkg::ROW_W'(1);
    res_med.col  = mf3_pkg::COL_W'(s1_col_q - CW'(1));
    res_med.last = !s1_bord_q;

    res_bord.pix  = s1_pix_q;
    res_bord.row  = s1_row_q;
    res_bord.col  = mf3_pkg::COL_W'(s1_col_q);
    res_bord.last = 1'b1;

    push.e0 = s1_med_q ? res_med : res_bord;
    push.e1 = res_bord;
    if (!s1_adv) begin
      push.cnt = 2'd0;
    end else if (s1_med_q && s1_bord_q) begin
      push.cnt = 2'd2;
    end else if (s1_med_q || s1_bord_q) begin
      push.cnt = 2'd1;
    end else begin
      push.cnt = 2'd0;
    end
  end

  mf3_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .head_o  (head)
  );

  assign pixel_out_o = head.pix;
  assign out_row_o   = head.row;
  assign out_col_o   = head.col;
  assign last_o      = head.last;

  // checks
  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted pixel did not reach the input stage");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= wm1_q)
    else $error("column counter beyond frame width");

  a_median_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_med_q) |-> (s1_row_q >= mf3_pkg::ROW_W'(2) && s1_col_q >= CW'(2)))
    else $error("median flagged outside the interior");

  a_stall_needs_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o))
    else $error("input stalled with nothing pending");

endmodule

`default_nettype wire
